FILE: sv/sat_pkg.sv
// shared types and constants of the acquisition trigger scheduler
`timescale 1ns / 1ps

package sat_pkg;

    localparam int CLK_W  = 32;
    localparam int HZ_W   = 10;
    localparam int RATE_W = 9;

    localparam int MAX_RATE_HZ = 500;

    // command codes
    localparam logic [2:0] FUNC_POLL     = 3'd0;
    localparam logic [2:0] FUNC_SET_MODE = 3'd1;
    localparam logic [2:0] FUNC_SET_RATE = 3'd2;
    localparam logic [2:0] FUNC_TRIGGER  = 3'd3;
    localparam logic [2:0] FUNC_STATUS   = 3'd4;

    // acquisition modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_CONT   = 2'd1;
    localparam logic [1:0] MODE_MANUAL = 2'd2;
    localparam logic [1:0] MODE_AUTO   = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_MODE   = 3'd1;
    localparam logic [2:0] ST_BAD_SENSOR = 3'd2;
    localparam logic [2:0] ST_BAD_RATE   = 3'd3;
    localparam logic [2:0] ST_INIT_FAIL  = 3'd4;
    localparam logic [2:0] ST_NO_MAG     = 3'd5;

    // sensor mask bits
    localparam int BIT_AK   = 0;
    localparam int BIT_TMAG = 1;
    localparam int BIT_IMU  = 2;

    // configuration register indexes
    localparam logic CFG_CORE_CLOCK = 1'b0;
    localparam logic CFG_AK_HZ      = 1'b1;

    localparam logic [CLK_W-1:0]  CORE_CLOCK_RESET = 32'd240000000;
    localparam logic [HZ_W-1:0]   AK_HZ_RESET      = 10'd480;
    localparam logic [RATE_W-1:0] DEFAULT_RATE     = 9'd100;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_ADD,
        S_UPD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_start;
        logic add;
        logic upd;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: sv/sat_div.sv
// serial restoring divider for the deadline period
`timescale 1ns / 1ps

module sat_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sat_pkg::CLK_W-1:0] num,
    input  logic [sat_pkg::HZ_W-1:0]  den,
    output logic                      done,
    output logic [sat_pkg::CLK_W-1:0] quo
);
    import sat_pkg::*;

    localparam int CNT_W = $clog2(CLK_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [HZ_W-1:0]  rem_reg;
    logic [CLK_W-1:0] quo_reg;
    logic [HZ_W-1:0]  den_reg;

    logic [HZ_W:0]    trial;
    logic [HZ_W:0]    diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[CLK_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CLK_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the difference fits
            rem_reg <= ge ? diff[HZ_W-1:0] : trial[HZ_W-1:0];
            quo_reg <= {quo_reg[CLK_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: sv/sat_datapath.sv
// settings, deadlines, command decode and output register of the scheduler
`timescale 1ns / 1ps

module sat_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sat_pkg::ctrl_cmd_t           cmd,
    output sat_pkg::dp_stat_t            stat,
    input  logic [47:0]                  s_tdata,
    input  logic [3:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [sat_pkg::CLK_W-1:0]    cfg_data
);
    import sat_pkg::*;

    // configuration
    logic [CLK_W-1:0]  clock_hz_reg;
    logic [HZ_W-1:0]   ak_hz_reg;

    // request fields
    logic [2:0]        func_reg;
    logic [CLK_W-1:0]  now_reg;
    logic [1:0]        strat_reg;
    logic [2:0]        smask_reg;
    logic [HZ_W-1:0]   rhz_reg;
    logic              has_rate_reg;
    logic              init_ok_reg;

    // scheduler state
    logic [1:0]        mode_reg;
    logic [2:0]        mask_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [CLK_W-1:0]  next_trig_reg;
    logic [CLK_W-1:0]  next_ak_reg;
    logic              pending_reg;

    // deadline work
    logic              fire_reg;
    logic              sel_ak_reg;
    logic [CLK_W-1:0]  d0_reg;
    logic [CLK_W-1:0]  sum_reg;
    logic [CLK_W-1:0]  alt_reg;

    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;

    logic              is_poll;
    logic              use_ak;
    logic              use_trig;
    logic [CLK_W-1:0]  dl;
    logic [CLK_W-1:0]  d0;
    logic [CLK_W-1:0]  since_d0;
    logic [CLK_W-1:0]  since_sum;
    logic [CLK_W-1:0]  dl_new;
    logic [HZ_W-1:0]   den;
    logic [CLK_W-1:0]  period;
    logic              div_done;
    logic              out_free;
    logic              commit;
    logic              rhz_valid;
    logic              fire;

    logic [2:0]        status;
    logic              r_imu, r_ak, r_tmag, t_ak, t_tmag;
    logic [1:0]        mode_next;
    logic [2:0]        mask_next;
    logic [RATE_W-1:0] rate_next;
    logic              pending_next;
    logic              clr_run;
    logic              clr_trig;
    logic [RATE_W-1:0] auto_hz;

    // deadline pre-check: an unarmed deadline arms to now and is due at once
    assign is_poll   = func_reg == FUNC_POLL;
    assign use_ak    = is_poll && mode_reg == MODE_CONT && mask_reg[BIT_AK];
    assign use_trig  = is_poll && mode_reg == MODE_AUTO && !pending_reg;
    assign dl        = use_ak ? next_ak_reg : next_trig_reg;
    assign d0        = (dl == '0) ? now_reg : dl;
    assign since_d0  = now_reg - d0;
    assign since_sum = now_reg - sum_reg;
    // a missed period restarts one period after now
    assign dl_new    = since_sum[CLK_W-1] ? sum_reg : alt_reg;

    always_comb
    begin
        if (use_ak)
            den = (ak_hz_reg == '0) ? HZ_W'(1) : ak_hz_reg;
        else
            den = (rate_reg == '0) ? HZ_W'(1) : HZ_W'(rate_reg);
    end

    sat_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (clock_hz_reg),
        .den   (den),
        .done  (div_done),
        .quo   (period)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = cmd.finish && out_free;

    assign stat.need_div = (use_ak || use_trig) && !since_d0[CLK_W-1];
    assign stat.div_done = div_done;
    assign stat.out_free = out_free;

    assign rhz_valid = rhz_reg != '0 && rhz_reg <= HZ_W'(MAX_RATE_HZ);
    assign fire      = pending_reg || fire_reg;

    always_comb
    begin
        status       = ST_OK;
        r_imu        = 1'b0;
        r_ak         = 1'b0;
        r_tmag       = 1'b0;
        t_ak         = 1'b0;
        t_tmag       = 1'b0;
        mode_next    = mode_reg;
        mask_next    = mask_reg;
        rate_next    = rate_reg;
        pending_next = pending_reg;
        clr_run      = 1'b0;
        clr_trig     = 1'b0;
        auto_hz      = DEFAULT_RATE;
        unique case (func_reg)
            FUNC_POLL:
            begin
                r_imu = mode_reg != MODE_IDLE && mask_reg[BIT_IMU];
                if (mode_reg == MODE_CONT)
                begin
                    r_ak   = mask_reg[BIT_AK] && fire_reg;
                    r_tmag = mask_reg[BIT_TMAG];
                end
                else if (mode_reg == MODE_MANUAL || mode_reg == MODE_AUTO)
                begin
                    if (fire)
                    begin
                        pending_next = 1'b0;
                        t_ak         = mask_reg[BIT_AK];
                        t_tmag       = mask_reg[BIT_TMAG];
                    end
                end
            end
            FUNC_SET_MODE:
            begin
                if (strat_reg == MODE_IDLE)
                begin
                    mode_next = MODE_IDLE;
                    mask_next = '0;
                    clr_run   = 1'b1;
                end
                else if (smask_reg == '0)
                begin
                    status = ST_BAD_SENSOR;
                end
                else
                begin
                    if (has_rate_reg && rhz_valid)
                        auto_hz = rhz_reg[RATE_W-1:0];
                    if (strat_reg == MODE_AUTO && has_rate_reg && !rhz_valid)
                        status = ST_BAD_RATE;
                    else if (!init_ok_reg)
                        status = ST_INIT_FAIL;
                    else
                    begin
                        mode_next = strat_reg;
                        mask_next = smask_reg;
                        if (strat_reg == MODE_AUTO)
                            rate_next = auto_hz;
                        clr_run   = 1'b1;
                    end
                end
            end
            FUNC_SET_RATE:
            begin
                if (!rhz_valid)
                    status = ST_BAD_RATE;
                else if (mode_reg != MODE_AUTO)
                    status = ST_BAD_MODE;
                else
                begin
                    rate_next = rhz_reg[RATE_W-1:0];
                    clr_trig  = 1'b1;
                end
            end
            FUNC_TRIGGER:
            begin
                if (mode_reg != MODE_MANUAL && mode_reg != MODE_AUTO)
                    status = ST_BAD_MODE;
                else if (!mask_reg[BIT_AK] && !mask_reg[BIT_TMAG])
                    status = ST_NO_MAG;
                else
                    pending_next = 1'b1;
            end
            FUNC_STATUS:
            begin
                status = ST_OK;
            end
            default:
            begin
                status = ST_BAD_MODE;
            end
        endcase
        if (clr_run)
            pending_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CORE_CLOCK_RESET;
            ak_hz_reg    <= AK_HZ_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CORE_CLOCK: clock_hz_reg <= cfg_data;
                CFG_AK_HZ:      ak_hz_reg    <= cfg_data[HZ_W-1:0];
                default:        ak_hz_reg    <= ak_hz_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg      <= s_tdata[31:0];
            strat_reg    <= s_tdata[33:32];
            smask_reg    <= s_tdata[36:34];
            rhz_reg      <= s_tdata[46:37];
            init_ok_reg  <= s_tdata[47];
            func_reg     <= s_tuser[2:0];
            has_rate_reg <= s_tuser[3];
        end
        if (cmd.eval)
        begin
            sel_ak_reg <= use_ak;
            d0_reg     <= d0;
        end
        if (cmd.add)
        begin
            sum_reg <= d0_reg + period;
            alt_reg <= now_reg + period;
        end
        if (commit)
        begin
            m_tdata_reg <= {2'b00, rate_next, mask_next, mode_next,
                            t_tmag, t_ak, r_tmag, r_ak, r_imu, status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            mask_reg      <= '0;
            rate_reg      <= DEFAULT_RATE;
            next_trig_reg <= '0;
            next_ak_reg   <= '0;
            pending_reg   <= 1'b0;
            fire_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
                fire_reg <= stat.need_div;
            if (cmd.upd)
            begin
                if (sel_ak_reg)
                    next_ak_reg <= dl_new;
                else
                    next_trig_reg <= dl_new;
            end
            if (commit)
            begin
                mode_reg    <= mode_next;
                mask_reg    <= mask_next;
                rate_reg    <= rate_next;
                pending_reg <= pending_next;
                if (clr_run)
                begin
                    next_trig_reg <= '0;
                    next_ak_reg   <= '0;
                end
                else if (clr_trig)
                begin
                    next_trig_reg <= '0;
                end
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: sv/sat_ctrl.sv
// sequencing state machine of the scheduler
`timescale 1ns / 1ps

module sat_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sat_pkg::dp_stat_t   stat,
    output sat_pkg::ctrl_cmd_t  cmd
);
    import sat_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (stat.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for room in the output register
                cmd.finish = 1'b1;
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/sensor_acquisition_trigger_scheduler.sv
// top level of the sensor acquisition trigger scheduler
`timescale 1ns / 1ps

// Acquisition mode controller for an imu and two magnetometer arrays. Each request
// (poll, set mode, set rate, manual trigger, status query) yields one result with a
// status code, the read and trigger strobes of a poll, and the settings after the
// request. A command passes through an evaluate state and a done state that waits
// for room in the output register. A poll whose ak or auto trigger deadline is due
// also takes a divide state: its period, core_clock_hz over the rate, comes from a
// 32-step serial divider, followed by states to add and to update the deadline. A
// finished result waits in the output register; the next request is taken meanwhile.
module sensor_acquisition_trigger_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now[31:0], strategy[33:32], sensors[36:34], rate_hz[46:37], init_ok[47]
    input  logic [47:0] s_tdata,
    // func[2:0], has_rate[3]
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], read_imu[3], read_ak[4], read_tmag[5], trigger_ak[6],
    // trigger_tmag[7], cur_mode[9:8], cur_sensors[12:10], cur_rate[21:13], zero[23:22]
    output logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import sat_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    sat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sat_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

FILE: verif/tb.sv
// self-checking testbench for the sensor acquisition trigger scheduler
`timescale 1ns / 1ps

module tb;

    import sat_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now;
        logic [1:0]  strategy;
        logic [2:0]  mask;
        logic [9:0]  rate_hz;
        logic        has_rate;
        logic        init_ok;
    } acq_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic       rd_imu;
        logic       rd_ak;
        logic       rd_tmag;
        logic       trg_ak;
        logic       trg_tmag;
        logic [1:0] mode;
        logic [2:0] sensors;
        logic [8:0] rate;
    } acq_res_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic [3:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data  = '0;

    sensor_acquisition_trigger_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // scheduler state as the checker sees it
    logic [1:0]  mode_q;
    logic [2:0]  mask_q;
    logic [8:0]  rate_q;
    logic [31:0] trig_dl;
    logic [31:0] ak_dl;
    logic        trig_pend;
    logic [31:0] clk_hz_m;
    logic [9:0]  ak_hz_m;

    // stimulus side view of the settings, used to pace the cycle count
    logic [31:0] gen_clk_hz;
    logic [9:0]  gen_ak_hz;
    logic [31:0] tick;

    acq_req_t request_q[$];
    acq_res_t answer_q[$];
    acq_req_t drive_req;

    int s_gap   = 0;
    int s_calm  = 0;
    int m_stall = 0;
    int m_calm  = 0;
    int m_gap_n;
    int quiet   = 0;
    int errors  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // true when the deadline is reached; rearms or catches up as needed
    function automatic logic deadline_hit(inout logic [31:0] dl, input logic [31:0] now,
                                          input logic [31:0] period);
        logic [31:0] diff;
        if (dl == 0)
            dl = now;
        diff = now - dl;
        if (diff[31])
            return 1'b0;
        dl = dl + period;
        diff = now - dl;
        if (!diff[31])
            dl = now + period;
        return 1'b1;
    endfunction

    function automatic void clear_run();
        trig_pend = 1'b0;
        trig_dl   = '0;
        ak_dl     = '0;
    endfunction

    function automatic acq_res_t schedule_step(input acq_req_t q);
        acq_res_t    r;
        logic [31:0] hz;
        logic        fire;
        r = '0;
        case (q.func)
            FUNC_POLL:
            begin
                r.rd_imu = (mode_q != MODE_IDLE) && mask_q[BIT_IMU];
                if (mode_q == MODE_CONT)
                begin
                    hz = (ak_hz_m == 0) ? 32'd1 : 32'(ak_hz_m);
                    if (mask_q[BIT_AK])
                        r.rd_ak = deadline_hit(ak_dl, q.now, clk_hz_m / hz);
                    r.rd_tmag = mask_q[BIT_TMAG];
                end
                else if (mode_q == MODE_MANUAL || mode_q == MODE_AUTO)
                begin
                    fire = trig_pend;
                    if (!fire && mode_q == MODE_AUTO)
                    begin
                        hz = (rate_q == 0) ? 32'd1 : 32'(rate_q);
                        fire = deadline_hit(trig_dl, q.now, clk_hz_m / hz);
                    end
                    if (fire)
                    begin
                        trig_pend  = 1'b0;
                        r.trg_ak   = mask_q[BIT_AK];
                        r.trg_tmag = mask_q[BIT_TMAG];
                    end
                end
            end
            FUNC_SET_MODE:
            begin
                if (q.strategy == MODE_IDLE)
                begin
                    mode_q = MODE_IDLE;
                    mask_q = '0;
                    clear_run();
                end
                else if (q.mask == 0)
                    r.status = ST_BAD_SENSOR;
                else
                begin
                    hz = 32'(rate_q);
                    if (q.strategy == MODE_AUTO)
                    begin
                        hz = 32'(DEFAULT_RATE);
                        if (q.has_rate)
                        begin
                            if (q.rate_hz >= 1 && q.rate_hz <= MAX_RATE_HZ)
                                hz = 32'(q.rate_hz);
                            else
                                r.status = ST_BAD_RATE;
                        end
                    end
                    if (r.status == ST_OK && !q.init_ok)
                        r.status = ST_INIT_FAIL;
                    if (r.status == ST_OK)
                    begin
                        mode_q = q.strategy;
                        mask_q = q.mask;
                        rate_q = hz[8:0];
                        clear_run();
                    end
                end
            end
            FUNC_SET_RATE:
            begin
                if (q.rate_hz < 1 || q.rate_hz > MAX_RATE_HZ)
                    r.status = ST_BAD_RATE;
                else if (mode_q != MODE_AUTO)
                    r.status = ST_BAD_MODE;
                else
                begin
                    rate_q  = q.rate_hz[8:0];
                    trig_dl = '0;
                end
            end
            FUNC_TRIGGER:
            begin
                if (mode_q != MODE_MANUAL && mode_q != MODE_AUTO)
                    r.status = ST_BAD_MODE;
                else if (!mask_q[BIT_AK] && !mask_q[BIT_TMAG])
                    r.status = ST_NO_MAG;
                else
                    trig_pend = 1'b1;
            end
            FUNC_STATUS:
                r.status = ST_OK;
            default:
                r.status = ST_BAD_MODE;
        endcase
        r.mode    = mode_q;
        r.sensors = mask_q;
        r.rate    = rate_q;
        return r;
    endfunction

    function automatic acq_req_t mk_req(input logic [2:0] f, input logic [31:0] n,
                                        input logic [1:0] st, input logic [2:0] sm,
                                        input logic [9:0] rh, input logic hr,
                                        input logic ok);
        acq_req_t q;
        q.func     = f;
        q.now      = n;
        q.strategy = st;
        q.mask     = sm;
        q.rate_hz  = rh;
        q.has_rate = hr;
        q.init_ok  = ok;
        return q;
    endfunction

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic cmp_field(input string name, input logic [8:0] want, input logic [8:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(input logic [23:0] d);
        acq_res_t w;
        if (answer_q.size() == 0)
        begin
            $error("result with nothing expected: %h", d);
            errors++;
            return;
        end
        w = answer_q.pop_front();
        cmp_field("status", 9'(w.status), 9'(d[2:0]));
        cmp_field("read_imu", 9'(w.rd_imu), 9'(d[3]));
        cmp_field("read_ak", 9'(w.rd_ak), 9'(d[4]));
        cmp_field("read_tmag", 9'(w.rd_tmag), 9'(d[5]));
        cmp_field("trigger_ak", 9'(w.trg_ak), 9'(d[6]));
        cmp_field("trigger_tmag", 9'(w.trg_tmag), 9'(d[7]));
        cmp_field("cur_mode", 9'(w.mode), 9'(d[9:8]));
        cmp_field("cur_sensors", 9'(w.sensors), 9'(d[12:10]));
        cmp_field("cur_rate", w.rate, d[21:13]);
        cmp_field("pad", 9'd0, 9'(d[23:22]));
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_gap    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                answer_q.push_back(schedule_step(drive_req));
            if (!s_tvalid || s_tready)
            begin
                if (s_gap != 0)
                begin
                    s_gap    <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    drive_req = request_q.pop_front();
                    s_tdata  <= {drive_req.init_ok, drive_req.rate_hz, drive_req.mask,
                                 drive_req.strategy, drive_req.now};
                    s_tuser  <= {drive_req.has_rate, drive_req.func};
                    s_tvalid <= 1'b1;
                    s_gap    <= pick_gap(s_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor; stalls start right after a result is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            m_stall  <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            check_result(m_tdata);
            m_gap_n = pick_gap(m_calm);
            m_stall  <= m_gap_n;
            m_tready <= (m_gap_n == 0);
        end
        else if (m_stall != 0)
        begin
            m_stall  <= m_stall - 1;
            m_tready <= (m_stall == 1);
        end
        else
            m_tready <= 1'b1;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CORE_CLOCK)
        begin
            clk_hz_m   = val;
            gen_clk_hz = val;
        end
        else
        begin
            ak_hz_m   = val[9:0];
            gen_ak_hz = val[9:0];
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (request_q.size() != 0 || s_tvalid || answer_q.size() != 0);
    endtask

    task automatic add_directed();
        request_q.push_back(mk_req(FUNC_STATUS, 32'hFFFF_FFFF, MODE_AUTO, 3'd7, 10'd1023,
                                   1'b1, 1'b1));
        request_q.push_back(mk_req(3'd5, 32'd7, MODE_CONT, 3'd1, 10'd3, 1'b0, 1'b1));
        request_q.push_back(mk_req(3'd7, 32'd0, MODE_IDLE, 3'd0, 10'd0, 1'b0, 1'b0));
        request_q.push_back(mk_req(FUNC_POLL, 32'd0, MODE_IDLE, 3'd0, 10'd0, 1'b0, 1'b0));
        request_q.push_back(mk_req(FUNC_SET_RATE, 32'd0, MODE_IDLE, 3'd0, 10'd250, 1'b0, 1'b0));
        request_q.push_back(mk_req(FUNC_SET_RATE, 32'd0, MODE_IDLE, 3'd0, 10'd0, 1'b0, 1'b0));
        request_q.push_back(mk_req(FUNC_SET_RATE, 32'd0, MODE_IDLE, 3'd0, 10'd1023, 1'b0, 1'b0));
        request_q.push_back(mk_req(FUNC_TRIGGER, 32'd0, MODE_IDLE, 3'd7, 10'd0, 1'b0, 1'b1));
        // checks in order: empty mask, bad explicit rate, failed init
        request_q.push_back(mk_req(FUNC_SET_MODE, 32'd0, MODE_CONT, 3'd0, 10'd0, 1'b0, 1'b1));
        request_q.push_back(mk_req(FUNC_SET_MODE, 32'd0, MODE_AUTO, 3'd3, 10'd0, 1'b1, 1'b0));
        request_q.push_back(mk_req(FUNC_SET_MODE, 32'd0, MODE_AUTO, 3'd3, 10'd501, 1'b1, 1'b1));
        request_q.push_back(mk_req(FUNC_SET_MODE, 32'd0, MODE_MANUAL, 3'd7, 10'd0, 1'b0, 1'b0));
        // imu only: a trigger finds no magnetometer
        request_q.push_back(mk_req(FUNC_SET_MODE, 32'd0, MODE_MANUAL, 3'd4, 10'd0, 1'b0, 1'b1));
        request_q.push_back(mk_req(FUNC_TRIGGER, 32'd0, MODE_IDLE, 3'd0, 10'd0, 1'b0, 1'b0));
        request_q.push_back(mk_req(FUNC_POLL, 32'd1000, MODE_IDLE, 3'd0, 10'd0, 1'b0, 1'b0));
        request_q.push_back(mk_req(FUNC_SET_MODE, 32'd0, MODE_MANUAL, 3'd7, 10'd0, 1'b0, 1'b1));
        request_q.push_back(mk_req(FUNC_TRIGGER, 32'd0, MODE_IDLE, 3'd0, 10'd0, 1'b0, 1'b0));
        request_q.push_back(mk_req(FUNC_POLL, 32'd2000, MODE_IDLE, 3'd0, 10'd0, 1'b0, 1'b0));
        // a poll at time zero fires and arms the deadline one period later
        request_q.push_back(mk_req(FUNC_SET_MODE, 32'd0, MODE_AUTO, 3'd3, 10'd500, 1'b1, 1'b1));
        request_q.push_back(mk_req(FUNC_POLL, 32'd0, MODE_IDLE, 3'd0, 10'd0, 1'b0, 1'b0));
        request_q.push_back(mk_req(FUNC_POLL, 32'hFFFF_FFFF, MODE_IDLE, 3'd0, 10'd0, 1'b0, 1'b0));
        request_q.push_back(mk_req(FUNC_SET_RATE, 32'd0, MODE_IDLE, 3'd0, 10'd1, 1'b0, 1'b0));
        request_q.push_back(mk_req(FUNC_POLL, 32'd480000, MODE_IDLE, 3'd0, 10'd0, 1'b0, 1'b0));
        request_q.push_back(mk_req(FUNC_SET_MODE, 32'd0, MODE_AUTO, 3'd1, 10'd1023, 1'b0, 1'b1));
        request_q.push_back(mk_req(FUNC_SET_MODE, 32'd0, MODE_CONT, 3'd7, 10'd0, 1'b0, 1'b1));
        request_q.push_back(mk_req(FUNC_POLL, 32'd100, MODE_IDLE, 3'd0, 10'd0, 1'b0, 1'b0));
        // a whole ak period missed
        request_q.push_back(mk_req(FUNC_POLL, 32'd2000000, MODE_IDLE, 3'd0, 10'd0, 1'b0, 1'b0));
        request_q.push_back(mk_req(FUNC_SET_MODE, 32'd0, MODE_IDLE, 3'd5, 10'd9, 1'b1, 1'b0));
    endtask

    // one mode set up, then polls paced against the expected period, mixed with commands
    task automatic add_session(input int n);
        acq_req_t    q;
        int          k;
        int          guess;
        logic [1:0]  strat;
        logic [9:0]  rhz;
        logic        hr;
        logic [31:0] scale;
        logic [63:0] step;
        strat = 2'($urandom_range(1, 3));
        hr    = 1'($urandom_range(0, 1));
        rhz   = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                            : 10'($urandom_range(1, MAX_RATE_HZ));
        request_q.push_back(mk_req(FUNC_SET_MODE, $urandom, strat, 3'($urandom_range(1, 7)), rhz,
                                   hr, $urandom_range(0, 19) != 0));
        guess = (strat == MODE_AUTO && hr) ? int'(rhz) : 100;
        if (strat == MODE_CONT)
            guess = (gen_ak_hz == 0) ? 1 : int'(gen_ak_hz);
        if (guess < 1 || guess > 1023)
            guess = 100;
        if ($urandom_range(0, 3) == 0)
            tick = 32'hFFFF_FFFF - $urandom_range(0, 5000000);
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            q = mk_req(3'($urandom_range(0, 7)), $urandom, 2'($urandom), 3'($urandom),
                       10'($urandom), 1'($urandom), 1'($urandom));
            if (k < 62)
            begin
                scale = gen_clk_hz / 32'(guess);
                k = $urandom_range(0, 99);
                if (k < 40)
                    step = 64'($urandom_range(0, scale / 4));
                else if (k < 80)
                    step = 64'(scale) * 3 / 4 + 64'($urandom_range(0, scale / 2));
                else if (k < 92)
                    step = 64'(scale) * 64'($urandom_range(2, 5));
                else
                    step = 64'($urandom) - 64'(tick);
                tick = tick + step[31:0];
                q.func = FUNC_POLL;
                q.now  = tick;
            end
            else if (k < 70)
                q.func = FUNC_TRIGGER;
            else if (k < 77)
            begin
                q.func = FUNC_SET_RATE;
                if ($urandom_range(0, 4) != 0)
                begin
                    q.rate_hz = 10'($urandom_range(1, MAX_RATE_HZ));
                    guess = int'(q.rate_hz);
                end
            end
            else if (k < 81)
                q.func = FUNC_STATUS;
            else if (k < 85)
                q.func = 3'($urandom_range(5, 7));
            else if (k < 93)
                q.func = FUNC_SET_MODE;
            request_q.push_back(q);
        end
    endtask

    task automatic add_random(input int n);
        int left;
        int len;
        left = n;
        while (left > 0)
        begin
            len = $urandom_range(5, 40);
            if (len > left)
                len = left;
            add_session(len);
            left -= len;
        end
    endtask

    initial
    begin
        mode_q     = MODE_IDLE;
        mask_q     = '0;
        rate_q     = DEFAULT_RATE;
        clear_run();
        clk_hz_m   = CORE_CLOCK_RESET;
        ak_hz_m    = AK_HZ_RESET;
        gen_clk_hz = CORE_CLOCK_RESET;
        gen_ak_hz  = AK_HZ_RESET;
        tick       = $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        add_directed();
        add_random(120);
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(CFG_CORE_CLOCK, 32'd1000);
                    write_reg(CFG_AK_HZ, 32'd0);
                end
                1:
                begin
                    write_reg(CFG_CORE_CLOCK, 32'hFFFF_FFFF);
                    write_reg(CFG_AK_HZ, 32'd1000);
                end
                2:
                begin
                    write_reg(CFG_CORE_CLOCK, 32'd1);
                    write_reg(CFG_AK_HZ, 32'd1);
                end
                3:
                begin
                    write_reg(CFG_CORE_CLOCK, $urandom_range(1000000, 300000000));
                    write_reg(CFG_AK_HZ, $urandom_range(1, 1023));
                end
                default:
                begin
                    write_reg(CFG_AK_HZ, 32'(AK_HZ_RESET));
                    write_reg(CFG_CORE_CLOCK, CORE_CLOCK_RESET);
                end
            endcase
            add_random(140);
            wait_drained();
        end

        repeat (60) @(posedge clk);
        if (errors == 0 && answer_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
